// ----- hw/rtl/bmp_rle_span_decoder_unit_macros.svh -----
// Assertion macros for the span decoder RTL.
`ifndef BMP_RLE_SPAN_DECODER_UNIT_MACROS_SVH
`define BMP_RLE_SPAN_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BRSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define BRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BRSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BRSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/brsd_pkg.sv -----
// Types and constants of the BMP RLE span decoder.
package brsd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int POS_BITS      = COORD_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = COORD_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FOUR_BIT_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_OFFSET  = 2'd3;

    localparam logic [COORD_BITS-1:0] RST_IMAGE_WIDTH  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] RST_IMAGE_HEIGHT = COORD_BITS'(480);

    localparam logic KIND_SPAN = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       image_start;
    } t_in_beat;

    typedef struct packed {
        logic                  result_kind;
        logic [COORD_BITS-1:0] span_x;
        logic [COORD_BITS-1:0] span_row;
        logic [7:0]            span_length;
        logic [7:0]            first_index;
        logic [7:0]            second_index;
    } t_out_beat;

endpackage

// ----- hw/rtl/bmp_rle_span_decoder_unit.sv -----
// BMP RLE8/RLE4 span decoder, top level.
// A byte is captured in the input register, then parsed and its result registered in the output register.
// Throughput: one byte per cycle while the output is not held; parser and position state update once per byte.
// A held result stalls the input only once the input register is also full.
// Reset (synchronous, active low) clears parser state and loads the default registers
// (RLE8, 640 x 480, offset 0).
module bmp_rle_span_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  brsd_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output brsd_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brsd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [brsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import brsd_pkg::*;

`include "bmp_rle_span_decoder_unit_macros.svh"

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_VALUE = 3'd1,
        PH_ABS   = 3'd2,
        PH_PAD   = 3'd3,
        PH_DX    = 3'd4,
        PH_DY    = 3'd5
    } t_phase;

    // configuration
    logic                  r_four_bit;
    logic [COORD_BITS-1:0] r_width;
    logic [COORD_BITS-1:0] r_height;
    logic [7:0]            r_index_offset;

    // pipeline registers
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    // parser state
    t_phase              r_ph,   n_ph,   s_ph;
    logic [7:0]          r_pend, n_pend, s_pend;
    logic [7:0]          r_abs,  n_abs,  s_abs;
    logic                r_odd,  n_odd,  s_odd;
    logic [POS_BITS-1:0] r_col,  n_col,  s_col;
    logic [POS_BITS-1:0] r_line, n_line, s_line;
    logic [7:0]          r_dcol, n_dcol, s_dcol;
    logic                r_fin,  n_fin,  s_fin;

    logic                out_free, adv, in_acc;
    logic [7:0]          b, b_off, pix, req_len, clip_len;
    logic                req_span, req_end, span_ok;
    logic [POS_BITS-1:0] w_ext, h_ext, room, line_inc, col_dlt, line_dlt;
    logic                n_out_valid;
    t_out_beat           n_out;

    function automatic logic oob(input logic [POS_BITS-1:0] line,
                                 input logic [POS_BITS-1:0] col,
                                 input logic [POS_BITS-1:0] w,
                                 input logic [POS_BITS-1:0] h);
        return (line >= h) || (col > w);
    endfunction

    assign out_free    = !r_out_valid || !i_out_stall;
    assign adv         = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign b     = r_in.stream_byte;
    assign b_off = (b != 8'd0) ? (b + r_index_offset) : 8'd0;
    assign w_ext = {1'b0, r_width};
    assign h_ext = {1'b0, r_height};

    // image_start clears the decoder before this byte is parsed
    assign s_ph   = r_in.image_start ? PH_COUNT : r_ph;
    assign s_pend = r_in.image_start ? 8'd0 : r_pend;
    assign s_abs  = r_in.image_start ? 8'd0 : r_abs;
    assign s_odd  = r_in.image_start ? 1'b0 : r_odd;
    assign s_col  = r_in.image_start ? '0 : r_col;
    assign s_line = r_in.image_start ? '0 : r_line;
    assign s_dcol = r_in.image_start ? 8'd0 : r_dcol;
    assign s_fin  = r_in.image_start ? 1'b0 : r_fin;

    assign line_inc = s_line + POS_BITS'(1);
    assign col_dlt  = s_col + POS_BITS'(s_dcol);
    assign line_dlt = s_line + POS_BITS'(b);

    // pixels taken by one absolute-run byte
    assign pix = r_four_bit ? ((s_abs >= 8'd2) ? 8'd2 : s_abs)
                            : ((s_abs >= 8'd1) ? 8'd1 : 8'd0);

    // clip to the row; room is only meaningful when the column is inside the row
    assign room     = w_ext - s_col;
    assign clip_len = (POS_BITS'(req_len) > room) ? room[7:0] : req_len;
    assign span_ok  = req_span && (s_line < h_ext) && (s_col < w_ext) && (clip_len != 8'd0);

    always_comb begin
        n_ph     = s_ph;
        n_pend   = s_pend;
        n_abs    = s_abs;
        n_odd    = s_odd;
        n_col    = s_col;
        n_line   = s_line;
        n_dcol   = s_dcol;
        n_fin    = s_fin;
        req_span = 1'b0;
        req_end  = 1'b0;
        req_len  = 8'd0;
        if (!s_fin) begin
            unique case (s_ph)
                PH_COUNT: begin
                    if (oob(s_line, s_col, w_ext, h_ext)) begin
                        req_end = 1'b1;
                    end else begin
                        n_pend = b;
                        n_ph   = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    n_ph = PH_COUNT;
                    if (s_pend != 8'd0) begin
                        req_span = 1'b1;
                        req_len  = s_pend;
                    end else if (b == 8'd0) begin
                        // end of line
                        n_line  = line_inc;
                        n_col   = '0;
                        req_end = oob(line_inc, '0, w_ext, h_ext);
                    end else if (b == 8'd1) begin
                        req_end = 1'b1;
                    end else if (b == 8'd2) begin
                        n_ph = PH_DX;
                    end else begin
                        n_abs = b;
                        n_odd = 1'b0;
                        n_ph  = PH_ABS;
                    end
                end
                PH_ABS: begin
                    n_abs = s_abs - pix;
                    n_odd = !s_odd;
                    if (n_abs == 8'd0) begin
                        // odd byte count gets a pad byte
                        n_ph = !s_odd ? PH_PAD : PH_COUNT;
                    end
                    req_span = 1'b1;
                    req_len  = pix;
                end
                PH_PAD: begin
                    n_ph = PH_COUNT;
                end
                PH_DX: begin
                    n_dcol = b;
                    n_ph   = PH_DY;
                end
                PH_DY: begin
                    n_col   = col_dlt;
                    n_line  = line_dlt;
                    n_ph    = PH_COUNT;
                    req_end = oob(line_dlt, col_dlt, w_ext, h_ext);
                end
                default: begin
                    n_ph = PH_COUNT;
                end
            endcase
        end
        if (span_ok) begin
            n_col = s_col + POS_BITS'(clip_len);
        end
        if (req_end) begin
            n_fin = 1'b1;
        end

        n_out_valid = req_end || span_ok;
        n_out       = '0;
        if (!req_end) begin
            n_out.result_kind = KIND_SPAN;
            n_out.span_x      = s_col[COORD_BITS-1:0];
            n_out.span_row    = COORD_BITS'(h_ext - POS_BITS'(1) - s_line);
            n_out.span_length = clip_len;
            if (r_four_bit) begin
                n_out.first_index  = {4'd0, b_off[7:4]};
                n_out.second_index = {4'd0, b_off[3:0]};
            end else begin
                n_out.first_index  = b_off;
                n_out.second_index = b_off;
            end
        end else begin
            n_out.result_kind = KIND_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit     <= 1'b0;
            r_width        <= RST_IMAGE_WIDTH;
            r_height       <= RST_IMAGE_HEIGHT;
            r_index_offset <= 8'd0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_ph           <= PH_COUNT;
            r_pend         <= 8'd0;
            r_abs          <= 8'd0;
            r_odd          <= 1'b0;
            r_col          <= '0;
            r_line         <= '0;
            r_dcol         <= 8'd0;
            r_fin          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FOUR_BIT_MODE: r_four_bit     <= i_cfg_data[0];
                    CFG_IMAGE_WIDTH:   r_width        <= i_cfg_data[COORD_BITS-1:0];
                    CFG_IMAGE_HEIGHT:  r_height       <= i_cfg_data[COORD_BITS-1:0];
                    CFG_INDEX_OFFSET:  r_index_offset <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid && n_out_valid;
            end
            if (adv) begin
                r_ph   <= n_ph;
                r_pend <= n_pend;
                r_abs  <= n_abs;
                r_odd  <= n_odd;
                r_col  <= n_col;
                r_line <= n_line;
                r_dcol <= n_dcol;
                r_fin  <= n_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    `BRSD_ASSERT_NEXT(a_fin_silent, i_clk, i_rst_n,
        adv && r_fin && !r_in.image_start, !r_out_valid)
    `BRSD_ASSERT_NEXT(a_end_sets_fin, i_clk, i_rst_n,
        adv && n_out_valid && (n_out.result_kind == KIND_END), r_fin)
    `BRSD_ASSERT_IMPLY(a_end_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.result_kind == KIND_END),
        (r_out.span_length == 8'd0) && (r_out.span_x == '0) && (r_out.first_index == 8'd0))
    `BRSD_ASSERT_IMPLY(a_span_in_row, i_clk, i_rst_n,
        r_out_valid && (r_out.result_kind == KIND_SPAN),
        (r_out.span_length != 8'd0) &&
        (({1'b0, r_out.span_x} + POS_BITS'(r_out.span_length)) <= {1'b0, r_width}))
    `BRSD_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_out_valid && i_out_stall)

endmodule

// ----- tb/sv/bmp_rle_span_decoder_unit_checker.sv -----
// Span decoder checker: tracks config writes, predicts span and end beats and compares them.
`timescale 1ns / 1ps

module bmp_rle_span_decoder_unit_checker
    import brsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_in_beat                 i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  t_out_beat                i_out_data,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_open_count
);

    typedef enum logic [2:0] {
        ST_RUN_COUNT,
        ST_RUN_VALUE,
        ST_ABS_DATA,
        ST_ABS_PAD,
        ST_DELTA_X,
        ST_DELTA_Y
    } t_parse_st;

    // register shadows
    logic                  rle4;
    logic [COORD_BITS-1:0] img_w;
    logic [COORD_BITS-1:0] img_h;
    logic [7:0]            idx_offset;

    // decoder state
    t_parse_st           parse_st;
    logic [7:0]          run_len;
    logic [7:0]          abs_left;
    logic                odd_read;
    logic [POS_BITS-1:0] cur_col;
    logic [POS_BITS-1:0] cur_line;
    logic [7:0]          skip_x;
    logic                img_done;

    t_out_beat expected_spans[$];
    int        fail_cnt = 0;

    task automatic clear_position();
        parse_st = ST_RUN_COUNT;
        run_len  = '0;
        abs_left = '0;
        odd_read = 1'b0;
        cur_col  = '0;
        cur_line = '0;
        skip_x   = '0;
        img_done = 1'b0;
    endtask

    function automatic bit past_edge();
        return (cur_line >= {1'b0, img_h}) || (cur_col > {1'b0, img_w});
    endfunction

    function automatic logic [7:0] add_offset(input logic [7:0] b);
        return (b == 8'd0) ? 8'd0 : b + idx_offset;
    endfunction

    task automatic mark_end(output bit got, output t_out_beat r);
        img_done      = 1'b1;
        got           = 1'b1;
        r             = '0;
        r.result_kind = KIND_END;
    endtask

    task automatic make_span(input logic [7:0] len_req, input logic [7:0] v,
                             output bit got, output t_out_beat r);
        logic [POS_BITS-1:0] room;
        logic [POS_BITS-1:0] len;
        got = 1'b0;
        r   = '0;
        if (cur_line >= {1'b0, img_h} || cur_col >= {1'b0, img_w})
            return;
        room = {1'b0, img_w} - cur_col;
        len  = (POS_BITS'(len_req) > room) ? room : POS_BITS'(len_req);
        if (len == 0)
            return;
        r.result_kind = KIND_SPAN;
        r.span_x      = cur_col[COORD_BITS-1:0];
        r.span_row    = img_h - COORD_BITS'(1) - cur_line[COORD_BITS-1:0];
        r.span_length = len[7:0];
        if (rle4) begin
            r.first_index  = {4'h0, v[7:4]};
            r.second_index = {4'h0, v[3:0]};
        end else begin
            r.first_index  = v;
            r.second_index = v;
        end
        cur_col = cur_col + len;
        got     = 1'b1;
    endtask

    task automatic decode_byte(input t_in_beat beat, output bit got, output t_out_beat r);
        logic [7:0] b;
        logic [7:0] pix;
        b   = beat.stream_byte;
        got = 1'b0;
        r   = '0;
        if (beat.image_start)
            clear_position();
        if (img_done)
            return;
        case (parse_st)
            ST_RUN_COUNT: begin
                if (past_edge()) begin
                    mark_end(got, r);
                end else begin
                    run_len  = b;
                    parse_st = ST_RUN_VALUE;
                end
            end
            ST_RUN_VALUE: begin
                parse_st = ST_RUN_COUNT;
                if (run_len != 8'd0) begin
                    make_span(run_len, add_offset(b), got, r);
                end else if (b == 8'd0) begin
                    // end of line
                    cur_line = cur_line + 1'b1;
                    cur_col  = '0;
                    if (past_edge())
                        mark_end(got, r);
                end else if (b == 8'd1) begin
                    mark_end(got, r);
                end else if (b == 8'd2) begin
                    parse_st = ST_DELTA_X;
                end else begin
                    abs_left = b;
                    odd_read = 1'b0;
                    parse_st = ST_ABS_DATA;
                end
            end
            ST_ABS_DATA: begin
                if (rle4)
                    pix = (abs_left >= 8'd2) ? 8'd2 : abs_left;
                else
                    pix = (abs_left != 8'd0) ? 8'd1 : 8'd0;
                abs_left = abs_left - pix;
                odd_read = ~odd_read;
                // absolute data is padded to an even byte count
                if (abs_left == 8'd0)
                    parse_st = odd_read ? ST_ABS_PAD : ST_RUN_COUNT;
                make_span(pix, add_offset(b), got, r);
            end
            ST_ABS_PAD: parse_st = ST_RUN_COUNT;
            ST_DELTA_X: begin
                skip_x   = b;
                parse_st = ST_DELTA_Y;
            end
            ST_DELTA_Y: begin
                cur_col  = cur_col + skip_x;
                cur_line = cur_line + b;
                parse_st = ST_RUN_COUNT;
                if (past_edge())
                    mark_end(got, r);
            end
            default: parse_st = ST_RUN_COUNT;
        endcase
    endtask

    function automatic void report_beat(input string what, input t_out_beat w,
                                        input t_out_beat a);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t %s: kind %0d/%0d x %0d/%0d row %0d/%0d len %0d/%0d idx %0h,%0h/%0h,%0h",
                     $time, what, w.result_kind, a.result_kind, w.span_x, a.span_x,
                     w.span_row, a.span_row, w.span_length, a.span_length,
                     w.first_index, w.second_index, a.first_index, a.second_index);
    endfunction

    always @(posedge i_clk) begin : track
        bit        got;
        t_out_beat want;
        if (!i_rst_n) begin
            rle4       = 1'b0;
            img_w      = RST_IMAGE_WIDTH;
            img_h      = RST_IMAGE_HEIGHT;
            idx_offset = 8'd0;
            clear_position();
            expected_spans.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FOUR_BIT_MODE: rle4       = i_cfg_data[0];
                    CFG_IMAGE_WIDTH:   img_w      = i_cfg_data;
                    CFG_IMAGE_HEIGHT:  img_h      = i_cfg_data;
                    CFG_INDEX_OFFSET:  idx_offset = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_spans.size() == 0) begin
                    report_beat("unexpected beat (exp/act)", '0, i_out_data);
                end else begin
                    want = expected_spans.pop_front();
                    if (want.result_kind !== i_out_data.result_kind ||
                        want.span_x !== i_out_data.span_x ||
                        want.span_row !== i_out_data.span_row ||
                        want.span_length !== i_out_data.span_length ||
                        want.first_index !== i_out_data.first_index ||
                        want.second_index !== i_out_data.second_index)
                        report_beat("mismatch (exp/act)", want, i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_data, got, want);
                if (got)
                    expected_spans.push_back(want);
            end
        end
        o_fail_count <= fail_cnt;
        o_open_count <= expected_spans.size();
    end

endmodule

// ----- tb/sv/bmp_rle_span_decoder_unit_test.sv -----
// Span decoder testbench top: RLE byte stream stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module bmp_rle_span_decoder_unit_test;
    import brsd_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                     i_clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    t_in_beat                 in_data;
    logic                     out_valid;
    logic                     out_stall;
    t_out_beat                out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int open_count;
    int idle_cycles = 0;
    int items_sent  = 0;

    bit start_next  = 1'b0;
    bit sender_gaps = 1'b0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit cur_rle4    = 1'b0;

    bmp_rle_span_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bmp_rle_span_decoder_unit_checker span_check (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall bursts, one long hold-off on request, none when quiet
    initial begin
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_data    <= '{stream_byte: b, image_start: start_next};
        start_next  = 1'b0;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // let every expected beat come back, then cover bytes still in flight
    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    task automatic write_config(input bit mode, input logic [11:0] w, input logic [11:0] h,
                                input logic [7:0] off);
        write_reg(CFG_FOUR_BIT_MODE, {11'd0, mode});
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_INDEX_OFFSET, {4'd0, off});
        cfg_valid <= 1'b0;
        cur_rle4   = mode;
    endtask

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 8'($urandom_range(1, 16));
        else if (r == 7)
            return 8'd255;
        return 8'($urandom);
    endfunction

    // one RLE record, mostly well formed, some broken or noise
    task automatic gen_record();
        int pick;
        int n;
        int nbytes;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_byte(pick_count());
            send_byte(8'($urandom));
        end else if (pick < 60) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 14);
            nbytes = cur_rle4 ? (n + 1) / 2 : n;
            if ($urandom_range(0, 9) == 0)
                nbytes = $urandom_range(0, nbytes + 2);
            send_byte(8'd0);
            send_byte(8'(n));
            repeat (nbytes) send_byte(8'($urandom));
            if (nbytes % 2)
                send_byte(8'($urandom));
        end else if (pick < 72) begin
            send_byte(8'd0);
            send_byte(8'd0);
        end else if (pick < 80) begin
            send_byte(8'd0);
            send_byte(8'd2);
            send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)));
            send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
        end else if (pick < 84) begin
            send_byte(8'd0);
            send_byte(8'd1);
            start_next = $urandom_range(0, 1);
        end else if (pick < 95) begin
            send_byte(8'($urandom));
        end else begin
            start_next = 1'b1;
        end
    endtask

    task automatic random_config(input int ph);
        logic [11:0] w;
        logic [11:0] h;
        logic [7:0]  off;
        int          r;
        r = $urandom_range(0, 9);
        w = (r == 0) ? 12'd1 : (r == 1) ? 12'd4095 :
            (r < 7) ? 12'($urandom_range(1, 48)) : 12'($urandom_range(1, 4095));
        r = $urandom_range(0, 9);
        h = (r == 0) ? 12'd1 : (r == 1) ? 12'd4095 :
            (r < 8) ? 12'($urandom_range(1, 12)) : 12'($urandom_range(1, 4095));
        r = $urandom_range(0, 4);
        off = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
        case (ph)
            0: write_config(1'b0, 12'd1, 12'd1, 8'd255);
            1: write_config(1'b1, 12'd4095, 12'd4095, 8'd0);
            2: write_config(1'b0, 12'd4095, 12'd4095, off);
            default: write_config($urandom_range(0, 1), w, h, off);
        endcase
    endtask

    initial begin
        int ph;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: RLE8, 640 x 480, no offset
        start_next = 1'b1;
        send_byte(8'd3);    send_byte(8'hAB);
        send_byte(8'd0);    send_byte(8'd0);      // end of line
        send_byte(8'd0);    send_byte(8'd2);      // delta
        send_byte(8'd5);    send_byte(8'd1);
        send_byte(8'd0);    send_byte(8'd3);      // odd absolute run, then pad
        send_byte(8'h10);   send_byte(8'h20);
        send_byte(8'hFF);   send_byte(8'h00);
        send_byte(8'd255);  send_byte(8'd0);      // longest run, zero value
        send_byte(8'd0);    send_byte(8'd1);      // end of bitmap
        send_byte(8'h7F);                         // ignored once finished
        wait_idle();

        // narrow RLE4 image: clipped run, empty span, end of line past the last row
        write_config(1'b1, 12'd3, 12'd1, 8'd255);
        start_next = 1'b1;
        send_byte(8'd8);    send_byte(8'h12);
        send_byte(8'd4);    send_byte(8'h00);
        send_byte(8'd0);    send_byte(8'd0);
        wait_idle();

        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            random_config(ph);
            sender_gaps = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) != 0)
                start_next = 1'b1;
            if (ph == 2) begin
                // receiver holds off while runs keep coming, so the input backs up
                start_next = 1'b1;
                hold_req   = 1'b1;
                while (hold_req) begin
                    send_byte(8'd1);
                    send_byte(8'($urandom));
                end
            end
            repeat ($urandom_range(20, 90)) gen_record();
            wait_idle();
            ph++;
        end

        quiet       = 1'b1;
        sender_gaps = 1'b0;
        random_config(ph);
        start_next = 1'b1;
        repeat (60) gen_record();
        wait_idle();

        if (fail_count == 0 && open_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
